FILE: hw/rtl/vnatc_pkg.sv
`timescale 1ns / 1ps

package vnatc_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 28;
  localparam int IBITS     = WORD_BITS - FRAC_BITS;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int CM_W   = RND_W + 1;
  localparam int OP_W   = CM_W + 2;
  localparam int LO_W   = (OP_W + 1) / 2;
  localparam int HI_W   = OP_W - LO_W;
  localparam int MAG_W  = 2 * OP_W;
  localparam int SUM_W  = MAG_W + 1;
  localparam int Q_W    = WORD_BITS + 1;

  localparam int CMUL_LAT = 2;
  localparam int CDIV_LAT = 5 + Q_W + 2;
  localparam int LAT      = CMUL_LAT + 1 + CDIV_LAT;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_T1    = 3'd0,
    CFG_T2    = 3'd1,
    CFG_T3    = 3'd2,
    CFG_LEAK  = 3'd3,
    CFG_RATIO = 3'd4,
    CFG_THRU  = 3'd5
  } cfg_idx_t;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [CM_W-1:0]      cm_t;
  typedef logic signed [OP_W-1:0]      op_t;
  typedef logic signed [MAG_W-1:0]     prod_t;

  localparam word_t SMAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam word_t SMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  typedef struct packed {
    logic [2*HI_W-1:0]      hh;
    logic [HI_W+LO_W:0]     hl;
    logic [HI_W+LO_W:0]     lh;
    logic [2*LO_W+1:0]      ll;
  } part_t;

  typedef struct packed {
    logic zero;
    logic zpos_re;
    logic zneg_re;
    logic zpos_im;
    logic zneg_im;
    logic neg_re;
    logic neg_im;
    logic sat_re;
    logic sat_im;
  } ctl_t;

  function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + (PROD_W'(1) << (FRAC_BITS - 1));
    return s[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic part_t pp_split(input op_t a, input op_t b);
    logic signed [HI_W-1:0] ah;
    logic signed [HI_W-1:0] bh;
    logic signed [LO_W:0]   al;
    logic signed [LO_W:0]   bl;
    logic signed [2*HI_W-1:0]  hh;
    logic signed [HI_W+LO_W:0] hl;
    logic signed [HI_W+LO_W:0] lh;
    logic signed [2*LO_W+1:0]  ll;
    part_t p;
    ah = a[OP_W-1:LO_W];
    bh = b[OP_W-1:LO_W];
    al = {1'b0, a[LO_W-1:0]};
    bl = {1'b0, b[LO_W-1:0]};
    hh = ah * bh;
    hl = ah * bl;
    lh = al * bh;
    ll = al * bl;
    p.hh = hh;
    p.hl = hl;
    p.lh = lh;
    p.ll = ll;
    return p;
  endfunction

  function automatic prod_t pp_join(input part_t p);
    prod_t hh;
    prod_t mid;
    prod_t ll;
    hh  = $signed(p.hh);
    mid = $signed(p.hl);
    mid = mid + $signed(p.lh);
    ll  = $signed(p.ll);
    return (hh << (2 * LO_W)) + (mid << LO_W) + ll;
  endfunction

endpackage

FILE: hw/rtl/vna_one_port_thru_correction.sv
`timescale 1ns / 1ps

// Applies a loaded one-port calibration and a thru normalization to each raw sweep point.
// A point can be taken in every clock cycle, and its corrected S11 and S21 come out of the
// two pipelined complex dividers, whose restoring quotient takes one bit per stage over 33
// stages. An output register with a skid stage lets the block take the next request while
// a result waits; the input stalls only while the skid stage is full. Coefficients are to be
// written by the user only while no point is in flight; the block does not enforce this.

module vna_one_port_thru_correction (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  vnatc_pkg::word_t                     raw_refl_re,
  input  vnatc_pkg::word_t                     raw_refl_im,
  input  vnatc_pkg::word_t                     raw_trans_re,
  input  vnatc_pkg::word_t                     raw_trans_im,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output vnatc_pkg::word_t                     s11_re,
  output vnatc_pkg::word_t                     s11_im,
  output vnatc_pkg::word_t                     s21_re,
  output vnatc_pkg::word_t                     s21_im,
  output logic                                 s11_invalid,
  output logic                                 s21_invalid,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vnatc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vnatc_pkg::CFG_W-1:0]          cfg_data
);

  localparam int LAT       = vnatc_pkg::LAT;
  localparam int OP_W      = vnatc_pkg::OP_W;
  localparam int WORD_BITS = vnatc_pkg::WORD_BITS;
  localparam int FRAC_BITS = vnatc_pkg::FRAC_BITS;
  localparam int CFG_W     = vnatc_pkg::CFG_W;
  localparam logic [CFG_W-1:0] ONE_RE = (CFG_W'(1) << FRAC_BITS) << (CFG_W / 2);

  logic [CFG_W-1:0] coef_t1, coef_t2, coef_t3, leak_offset, leak_ratio, thru_reference;

  vnatc_pkg::word_t t1_re, t1_im, t2_re, t2_im, t3_re, t3_im;
  vnatc_pkg::word_t off_re, off_im, rat_re, rat_im, thr_re, thr_im;

  logic en;
  logic [LAT-1:0] vld;

  vnatc_pkg::word_t m_re1, m_im1, x_re1, x_im1;
  vnatc_pkg::op_t   n11_re2, n11_im2, xo_re2, xo_im2, to_re2, to_im2;
  vnatc_pkg::op_t   n11_re3, n11_im3, d11_re3, d11_im3;
  vnatc_pkg::op_t   n21_re3, n21_im3, d21_re3, d21_im3;
  vnatc_pkg::cm_t   p11_re, p11_im, p21_re, p21_im;

  vnatc_pkg::word_t r11_re, r11_im, r21_re, r21_im;
  logic             r11_inv, r21_inv;

  logic             skid_valid;
  vnatc_pkg::word_t sk11_re, sk11_im, sk21_re, sk21_im;
  logic             sk11_inv, sk21_inv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_t1        <= ONE_RE;
      coef_t2        <= '0;
      coef_t3        <= '0;
      leak_offset    <= '0;
      leak_ratio     <= '0;
      thru_reference <= ONE_RE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vnatc_pkg::CFG_T1:    coef_t1        <= cfg_data;
        vnatc_pkg::CFG_T2:    coef_t2        <= cfg_data;
        vnatc_pkg::CFG_T3:    coef_t3        <= cfg_data;
        vnatc_pkg::CFG_LEAK:  leak_offset    <= cfg_data;
        vnatc_pkg::CFG_RATIO: leak_ratio     <= cfg_data;
        vnatc_pkg::CFG_THRU:  thru_reference <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign t1_re  = coef_t1[CFG_W/2 +: WORD_BITS];
  assign t1_im  = coef_t1[0 +: WORD_BITS];
  assign t2_re  = coef_t2[CFG_W/2 +: WORD_BITS];
  assign t2_im  = coef_t2[0 +: WORD_BITS];
  assign t3_re  = coef_t3[CFG_W/2 +: WORD_BITS];
  assign t3_im  = coef_t3[0 +: WORD_BITS];
  assign off_re = leak_offset[CFG_W/2 +: WORD_BITS];
  assign off_im = leak_offset[0 +: WORD_BITS];
  assign rat_re = leak_ratio[CFG_W/2 +: WORD_BITS];
  assign rat_im = leak_ratio[0 +: WORD_BITS];
  assign thr_re = thru_reference[CFG_W/2 +: WORD_BITS];
  assign thr_im = thru_reference[0 +: WORD_BITS];

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  vnatc_cmul u_cmul_refl (
    .clk  (clk),
    .en   (en),
    .a_re (raw_refl_re),
    .a_im (raw_refl_im),
    .b_re (t3_re),
    .b_im (t3_im),
    .p_re (p11_re),
    .p_im (p11_im)
  );

  vnatc_cmul u_cmul_leak (
    .clk  (clk),
    .en   (en),
    .a_re (raw_refl_re),
    .a_im (raw_refl_im),
    .b_re (rat_re),
    .b_im (rat_im),
    .p_re (p21_re),
    .p_im (p21_im)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      m_re1 <= raw_refl_re;
      m_im1 <= raw_refl_im;
      x_re1 <= raw_trans_re;
      x_im1 <= raw_trans_im;

      n11_re2 <= OP_W'(m_re1) - OP_W'(t2_re);
      n11_im2 <= OP_W'(m_im1) - OP_W'(t2_im);
      xo_re2  <= OP_W'(x_re1) - OP_W'(off_re);
      xo_im2  <= OP_W'(x_im1) - OP_W'(off_im);
      to_re2  <= OP_W'(thr_re) - OP_W'(off_re);
      to_im2  <= OP_W'(thr_im) - OP_W'(off_im);

      n11_re3 <= n11_re2;
      n11_im3 <= n11_im2;
      d11_re3 <= OP_W'(t1_re) - OP_W'(p11_re);
      d11_im3 <= OP_W'(t1_im) - OP_W'(p11_im);
      n21_re3 <= xo_re2 - OP_W'(p21_re);
      n21_im3 <= xo_im2 - OP_W'(p21_im);
      d21_re3 <= to_re2 - OP_W'(p21_re);
      d21_im3 <= to_im2 - OP_W'(p21_im);
    end
  end

  vnatc_cdiv u_cdiv_s11 (
    .clk     (clk),
    .en      (en),
    .n_re    (n11_re3),
    .n_im    (n11_im3),
    .d_re    (d11_re3),
    .d_im    (d11_im3),
    .q_re    (r11_re),
    .q_im    (r11_im),
    .invalid (r11_inv)
  );

  vnatc_cdiv u_cdiv_s21 (
    .clk     (clk),
    .en      (en),
    .n_re    (n21_re3),
    .n_im    (n21_im3),
    .d_re    (d21_re3),
    .d_im    (d21_im3),
    .q_re    (r21_re),
    .q_im    (r21_im),
    .invalid (r21_inv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[LAT-1] && out_stall) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      sk11_re  <= r11_re;
      sk11_im  <= r11_im;
      sk21_re  <= r21_re;
      sk21_im  <= r21_im;
      sk11_inv <= r11_inv;
      sk21_inv <= r21_inv;
    end
  end

  assign out_valid   = skid_valid || vld[LAT-1];
  assign s11_re      = skid_valid ? sk11_re  : r11_re;
  assign s11_im      = skid_valid ? sk11_im  : r11_im;
  assign s21_re      = skid_valid ? sk21_re  : r21_re;
  assign s21_im      = skid_valid ? sk21_im  : r21_im;
  assign s11_invalid = skid_valid ? sk11_inv : r11_inv;
  assign s21_invalid = skid_valid ? sk21_inv : r21_inv;

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("Accepted request did not enter the pipeline.");

  a_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(vld))
    else $error("Pipeline moved while the skid stage was full.");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    vld[LAT-1] && out_stall && !skid_valid |=> skid_valid)
    else $error("Stalled result was not caught by the skid stage.");

  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && $stable(sk11_re) && $stable(sk21_re))
    else $error("Skid stage lost a stalled result.");

endmodule

FILE: hw/rtl/vnatc_cmul.sv
`timescale 1ns / 1ps

module vnatc_cmul (
  input  logic              clk,
  input  logic              en,
  input  vnatc_pkg::word_t  a_re,
  input  vnatc_pkg::word_t  a_im,
  input  vnatc_pkg::word_t  b_re,
  input  vnatc_pkg::word_t  b_im,
  output vnatc_pkg::cm_t    p_re,
  output vnatc_pkg::cm_t    p_im
);

  localparam int PROD_W = vnatc_pkg::PROD_W;
  localparam int CM_W   = vnatc_pkg::CM_W;

  logic signed [PROD_W-1:0] prr;
  logic signed [PROD_W-1:0] pii;
  logic signed [PROD_W-1:0] pri;
  logic signed [PROD_W-1:0] pir;

  always_ff @(posedge clk) begin
    if (en) begin
      prr <= a_re * b_re;
      pii <= a_im * b_im;
      pri <= a_re * b_im;
      pir <= a_im * b_re;
      p_re <= CM_W'(vnatc_pkg::rnd(prr)) - CM_W'(vnatc_pkg::rnd(pii));
      p_im <= CM_W'(vnatc_pkg::rnd(pri)) + CM_W'(vnatc_pkg::rnd(pir));
    end
  end

endmodule

FILE: hw/rtl/vnatc_cdiv.sv
`timescale 1ns / 1ps

module vnatc_cdiv (
  input  logic              clk,
  input  logic              en,
  input  vnatc_pkg::op_t    n_re,
  input  vnatc_pkg::op_t    n_im,
  input  vnatc_pkg::op_t    d_re,
  input  vnatc_pkg::op_t    d_im,
  output vnatc_pkg::word_t  q_re,
  output vnatc_pkg::word_t  q_im,
  output logic              invalid
);

  localparam int MAG_W     = vnatc_pkg::MAG_W;
  localparam int SUM_W     = vnatc_pkg::SUM_W;
  localparam int Q_W       = vnatc_pkg::Q_W;
  localparam int IBITS     = vnatc_pkg::IBITS;
  localparam int WORD_BITS = vnatc_pkg::WORD_BITS;
  localparam int OP_W      = vnatc_pkg::OP_W;
  localparam logic [Q_W-1:0] HALF = Q_W'(1) << (WORD_BITS - 1);

  vnatc_pkg::part_t pt_dr, pt_di, pt_a, pt_b, pt_c, pt_d;
  vnatc_pkg::prod_t sq_r, sq_i, pa, pb, pc, pd;
  vnatc_pkg::ctl_t  ctl1, ctl2, ctl3, ctl4, ctl_f;
  vnatc_pkg::ctl_t  ctl1_next, ctl4_next, ctl5_next;

  logic [MAG_W-1:0]        den3, den4;
  logic signed [SUM_W-1:0] nre3, nim3;
  logic signed [SUM_W-1:0] abs_re, abs_im;
  logic [MAG_W-1:0]        mag_re4, mag_im4;
  logic [MAG_W-1:0]        sh_re, sh_im;

  logic [MAG_W-1:0]      rem_re [0:Q_W];
  logic [MAG_W-1:0]      rem_im [0:Q_W];
  logic [Q_W-1:0]        quo_re [0:Q_W];
  logic [Q_W-1:0]        quo_im [0:Q_W];
  logic [Q_W-1:0]        feed_re [0:Q_W];
  logic [Q_W-1:0]        feed_im [0:Q_W];
  logic [MAG_W-1:0]      den_s [0:Q_W];
  vnatc_pkg::ctl_t       ctl_s [0:Q_W];

  logic [Q_W:0]     inc_re, inc_im;
  logic [Q_W-1:0]   qr_re, qr_im;
  logic [Q_W-1:0]   nq_re, nq_im;
  logic             ovf_re, ovf_im;
  vnatc_pkg::word_t q_re_next, q_im_next;
  logic             invalid_next;

  always_comb begin
    ctl1_next = '0;
    ctl1_next.zero    = (d_re == '0) && (d_im == '0);
    ctl1_next.zpos_re = !n_re[OP_W-1] && (n_re != '0);
    ctl1_next.zneg_re = n_re[OP_W-1];
    ctl1_next.zpos_im = !n_im[OP_W-1] && (n_im != '0);
    ctl1_next.zneg_im = n_im[OP_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_dr <= vnatc_pkg::pp_split(d_re, d_re);
      pt_di <= vnatc_pkg::pp_split(d_im, d_im);
      pt_a  <= vnatc_pkg::pp_split(n_re, d_re);
      pt_b  <= vnatc_pkg::pp_split(n_im, d_im);
      pt_c  <= vnatc_pkg::pp_split(n_im, d_re);
      pt_d  <= vnatc_pkg::pp_split(n_re, d_im);
      ctl1  <= ctl1_next;

      sq_r <= vnatc_pkg::pp_join(pt_dr);
      sq_i <= vnatc_pkg::pp_join(pt_di);
      pa   <= vnatc_pkg::pp_join(pt_a);
      pb   <= vnatc_pkg::pp_join(pt_b);
      pc   <= vnatc_pkg::pp_join(pt_c);
      pd   <= vnatc_pkg::pp_join(pt_d);
      ctl2 <= ctl1;

      den3 <= $unsigned(sq_r) + $unsigned(sq_i);
      nre3 <= SUM_W'(pa) + SUM_W'(pb);
      nim3 <= SUM_W'(pc) - SUM_W'(pd);
      ctl3 <= ctl2;

      mag_re4 <= abs_re[MAG_W-1:0];
      mag_im4 <= abs_im[MAG_W-1:0];
      den4    <= den3;
      ctl4    <= ctl4_next;

      rem_re[0]  <= sh_re;
      rem_im[0]  <= sh_im;
      quo_re[0]  <= '0;
      quo_im[0]  <= '0;
      feed_re[0] <= Q_W'(mag_re4[IBITS-1:0]) << (Q_W - IBITS);
      feed_im[0] <= Q_W'(mag_im4[IBITS-1:0]) << (Q_W - IBITS);
      den_s[0]   <= den4;
      ctl_s[0]   <= ctl5_next;
    end
  end

  always_comb begin
    abs_re = nre3[SUM_W-1] ? -nre3 : nre3;
    abs_im = nim3[SUM_W-1] ? -nim3 : nim3;
    ctl4_next = ctl3;
    ctl4_next.neg_re = nre3[SUM_W-1];
    ctl4_next.neg_im = nim3[SUM_W-1];
  end

  always_comb begin
    sh_re = mag_re4 >> IBITS;
    sh_im = mag_im4 >> IBITS;
    ctl5_next = ctl4;
    ctl5_next.sat_re = sh_re >= den4;
    ctl5_next.sat_im = sh_im >= den4;
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic [MAG_W:0] t_re, t_im;
    logic [MAG_W:0] df_re, df_im;
    logic           ge_re, ge_im;

    assign t_re  = {rem_re[j], feed_re[j][Q_W-1]};
    assign t_im  = {rem_im[j], feed_im[j][Q_W-1]};
    assign df_re = t_re - {1'b0, den_s[j]};
    assign df_im = t_im - {1'b0, den_s[j]};
    assign ge_re = t_re >= {1'b0, den_s[j]};
    assign ge_im = t_im >= {1'b0, den_s[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_re[j+1]  <= ge_re ? df_re[MAG_W-1:0] : t_re[MAG_W-1:0];
        rem_im[j+1]  <= ge_im ? df_im[MAG_W-1:0] : t_im[MAG_W-1:0];
        quo_re[j+1]  <= {quo_re[j][Q_W-2:0], ge_re};
        quo_im[j+1]  <= {quo_im[j][Q_W-2:0], ge_im};
        feed_re[j+1] <= feed_re[j] << 1;
        feed_im[j+1] <= feed_im[j] << 1;
        den_s[j+1]   <= den_s[j];
        ctl_s[j+1]   <= ctl_s[j];
      end
    end
  end

  assign inc_re = {1'b0, quo_re[Q_W]} + 1'b1;
  assign inc_im = {1'b0, quo_im[Q_W]} + 1'b1;

  always_comb begin
    nq_re  = '0 - qr_re;
    nq_im  = '0 - qr_im;
    ovf_re = ctl_f.sat_re || (ctl_f.neg_re ? (qr_re > HALF) : (qr_re >= HALF));
    ovf_im = ctl_f.sat_im || (ctl_f.neg_im ? (qr_im > HALF) : (qr_im >= HALF));
    priority if (ctl_f.zero) begin
      q_re_next = ctl_f.zpos_re ? vnatc_pkg::SMAX :
                  (ctl_f.zneg_re ? vnatc_pkg::SMIN : '0);
      q_im_next = ctl_f.zpos_im ? vnatc_pkg::SMAX :
                  (ctl_f.zneg_im ? vnatc_pkg::SMIN : '0);
      invalid_next = 1'b1;
    end else begin
      if (ovf_re) begin
        q_re_next = ctl_f.neg_re ? vnatc_pkg::SMIN : vnatc_pkg::SMAX;
      end else begin
        q_re_next = ctl_f.neg_re ? nq_re[WORD_BITS-1:0] : qr_re[WORD_BITS-1:0];
      end
      if (ovf_im) begin
        q_im_next = ctl_f.neg_im ? vnatc_pkg::SMIN : vnatc_pkg::SMAX;
      end else begin
        q_im_next = ctl_f.neg_im ? nq_im[WORD_BITS-1:0] : qr_im[WORD_BITS-1:0];
      end
      invalid_next = ovf_re || ovf_im;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr_re   <= inc_re[Q_W:1];
      qr_im   <= inc_im[Q_W:1];
      ctl_f   <= ctl_s[Q_W];
      q_re    <= q_re_next;
      q_im    <= q_im_next;
      invalid <= invalid_next;
    end
  end

endmodule
